@@ hdl/dfsbt_pkg.sv @@
// Package for the depth-first path search block: microcode types, codes and program ROM.
// No dependencies.
package dfsbt_pkg;

  localparam int STEP_BITS = 4;

  typedef logic [STEP_BITS-1:0] step_t;

  // Datapath operations.
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_IDLE  = 4'd1;
  localparam logic [3:0] OP_FETCH = 4'd2;
  localparam logic [3:0] OP_SCAN  = 4'd3;
  localparam logic [3:0] OP_TAKE  = 4'd4;
  localparam logic [3:0] OP_POP   = 4'd5;
  localparam logic [3:0] OP_LOAD  = 4'd6;
  localparam logic [3:0] OP_PUSH  = 4'd7;
  localparam logic [3:0] OP_EMIT0 = 4'd8;
  localparam logic [3:0] OP_EMIT  = 4'd9;
  localparam logic [3:0] OP_FAIL  = 4'd10;

  // Jump conditions.
  localparam logic [3:0] CND_NEXT     = 4'd0;
  localparam logic [3:0] CND_ALWAYS   = 4'd1;
  localparam logic [3:0] CND_QUERY    = 4'd2;
  localparam logic [3:0] CND_EMPTY    = 4'd3;
  localparam logic [3:0] CND_SCAN_END = 4'd4;
  localparam logic [3:0] CND_DIRECT   = 4'd5;
  localparam logic [3:0] CND_FOUND    = 4'd6;
  localparam logic [3:0] CND_NODEPTH  = 4'd7;
  localparam logic [3:0] CND_EMIT_END = 4'd8;

  // Program addresses.
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_FETCH  = 4'd1;
  localparam step_t ST_SCAN   = 4'd2;
  localparam step_t ST_DECIDE = 4'd3;
  localparam step_t ST_TRYOPN = 4'd4;
  localparam step_t ST_TRYPOP = 4'd5;
  localparam step_t ST_POP    = 4'd6;
  localparam step_t ST_LOAD   = 4'd7;
  localparam step_t ST_PUSHOK = 4'd8;
  localparam step_t ST_TAKE   = 4'd9;
  localparam step_t ST_EMIT0  = 4'd10;
  localparam step_t ST_EMIT   = 4'd11;
  localparam step_t ST_FAIL   = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] cond;
    logic       hold;   // stay on this step while cond is false
    step_t      target;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    case (step)
      ST_IDLE:   w = '{op: OP_IDLE,  cond: CND_QUERY,    hold: 1'b1, target: ST_FETCH};
      ST_FETCH:  w = '{op: OP_FETCH, cond: CND_EMPTY,    hold: 1'b0, target: ST_DECIDE};
      ST_SCAN:   w = '{op: OP_SCAN,  cond: CND_SCAN_END, hold: 1'b1, target: ST_DECIDE};
      ST_DECIDE: w = '{op: OP_NONE,  cond: CND_DIRECT,   hold: 1'b0, target: ST_PUSHOK};
      ST_TRYOPN: w = '{op: OP_NONE,  cond: CND_FOUND,    hold: 1'b0, target: ST_TAKE};
      ST_TRYPOP: w = '{op: OP_NONE,  cond: CND_NODEPTH,  hold: 1'b0, target: ST_FAIL};
      ST_POP:    w = '{op: OP_POP,   cond: CND_NEXT,     hold: 1'b0, target: ST_IDLE};
      ST_LOAD:   w = '{op: OP_LOAD,  cond: CND_ALWAYS,   hold: 1'b0, target: ST_FETCH};
      ST_PUSHOK: w = '{op: OP_PUSH,  cond: CND_ALWAYS,   hold: 1'b0, target: ST_EMIT0};
      ST_TAKE:   w = '{op: OP_TAKE,  cond: CND_ALWAYS,   hold: 1'b0, target: ST_FETCH};
      ST_EMIT0:  w = '{op: OP_EMIT0, cond: CND_NEXT,     hold: 1'b0, target: ST_IDLE};
      ST_EMIT:   w = '{op: OP_EMIT,  cond: CND_EMIT_END, hold: 1'b1, target: ST_IDLE};
      ST_FAIL:   w = '{op: OP_FAIL,  cond: CND_ALWAYS,   hold: 1'b0, target: ST_IDLE};
      default:   w = '{op: OP_NONE,  cond: CND_ALWAYS,   hold: 1'b0, target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/dfs_backtrack_path_search.sv @@
// Depth-first path search with backtracking over a directed edge table, microcoded control.
// Depends on dfsbt_pkg (control word type, codes, program ROM).
//
// An add word (in_kind 0) is taken while idle and appends an edge unless the table is full.
// A query word (in_kind 1) holds busy high while the search runs: every node visit is one
// sequential scan of the edge table, one edge per cycle through the edge memory's read port.
// Results come out one per cycle on out_valid and cannot be stalled; the last one carries
// out_last. A failed search gives a single word with out_found low.
module dfs_backtrack_path_search
  import dfsbt_pkg::*;
#(
  parameter int MAX_EDGES    = 64,
  parameter int NODE_ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_src_node,
  input  logic [7:0] in_dst_node,
  output logic       out_valid,
  output logic [7:0] out_path_node,
  output logic       out_found,
  output logic       out_last
);

  localparam int NB = NODE_ID_BITS;
  localparam int IW = $clog2(MAX_EDGES);
  localparam int DW = $clog2(MAX_EDGES + 1);

  typedef logic [NB-1:0] node_t;
  typedef logic [IW-1:0] idx_t;
  typedef logic [DW-1:0] cnt_t;

  // sequencer
  step_t step_r, step_nxt;
  ctrl_t cw;
  logic  cond_true;
  logic  accept;

  // datapath registers
  cnt_t               edge_cnt_r, edge_cnt_nxt;
  cnt_t               depth_r, depth_nxt;
  logic [MAX_EDGES-1:0] used_r, used_nxt;
  node_t              cur_r, cur_nxt;
  node_t              goal_r, goal_nxt;
  idx_t               scan_r, scan_nxt;
  idx_t               first_r, first_nxt;
  node_t              ftgt_r, ftgt_nxt;
  logic               direct_r, direct_nxt;
  logic               found_r, found_nxt;
  cnt_t               oi_r, oi_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_node_r, out_node_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_last_r, out_last_nxt;

  // memories
  logic [2*NB-1:0] edge_mem [MAX_EDGES];
  logic [2*NB-1:0] edge_q;
  node_t           stack_mem [MAX_EDGES];
  node_t           stack_q;

  logic            edge_we;
  idx_t            edge_raddr;
  logic            stack_we;
  idx_t            stack_raddr;

  // input and output id conversion
  logic [NB+7:0] src_ext, dst_ext, node_ext;
  node_t         src_id, dst_id;
  node_t         q_src, q_tgt;
  cnt_t          scan_inc, oi_inc;
  logic          hit_src, direct_now, scan_last;

  assign src_ext  = {{NB{1'b0}}, in_src_node};
  assign dst_ext  = {{NB{1'b0}}, in_dst_node};
  assign src_id   = src_ext[NB-1:0];
  assign dst_id   = dst_ext[NB-1:0];
  assign node_ext = {8'b0, stack_q};

  assign q_src = edge_q[2*NB-1:NB];
  assign q_tgt = edge_q[NB-1:0];

  assign scan_inc   = cnt_t'(scan_r) + cnt_t'(1);
  assign oi_inc     = oi_r + cnt_t'(1);
  assign hit_src    = (q_src == cur_r);
  assign direct_now = direct_r | (hit_src & (q_tgt == goal_r));
  assign scan_last  = (scan_inc == edge_cnt_r);

  assign cw     = ucode_rom(step_r);
  assign busy   = (cw.op != OP_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    case (cw.cond)
      CND_NEXT:     cond_true = 1'b0;
      CND_ALWAYS:   cond_true = 1'b1;
      CND_QUERY:    cond_true = accept & in_kind;
      CND_EMPTY:    cond_true = (edge_cnt_r == '0);
      CND_SCAN_END: cond_true = direct_now | scan_last;
      CND_DIRECT:   cond_true = direct_r;
      CND_FOUND:    cond_true = found_r;
      CND_NODEPTH:  cond_true = (depth_r == '0);
      CND_EMIT_END: cond_true = (oi_inc == depth_r);
      default:      cond_true = 1'b0;
    endcase
    if (cond_true) begin
      step_nxt = cw.target;
    end else if (cw.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_comb begin
    edge_cnt_nxt  = edge_cnt_r;
    depth_nxt     = depth_r;
    used_nxt      = used_r;
    cur_nxt       = cur_r;
    goal_nxt      = goal_r;
    scan_nxt      = scan_r;
    first_nxt     = first_r;
    ftgt_nxt      = ftgt_r;
    direct_nxt    = direct_r;
    found_nxt     = found_r;
    oi_nxt        = oi_r;
    out_valid_nxt = 1'b0;
    out_node_nxt  = out_node_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    edge_we       = 1'b0;
    edge_raddr    = scan_inc[IW-1:0];
    stack_we      = 1'b0;
    stack_raddr   = oi_inc[IW-1:0];

    case (cw.op)
      OP_IDLE: begin
        if (accept && !in_kind) begin
          if (edge_cnt_r < cnt_t'(MAX_EDGES)) begin
            edge_we      = 1'b1;
            edge_cnt_nxt = edge_cnt_r + cnt_t'(1);
          end
        end else if (accept) begin
          used_nxt  = '0;
          depth_nxt = '0;
          cur_nxt   = src_id;
          goal_nxt  = dst_id;
        end
      end
      OP_FETCH: begin
        edge_raddr = '0;
        scan_nxt   = '0;
        direct_nxt = 1'b0;
        found_nxt  = 1'b0;
      end
      OP_SCAN: begin
        scan_nxt   = scan_inc[IW-1:0];
        direct_nxt = direct_now;
        if (hit_src && !used_r[scan_r] && !found_r) begin
          found_nxt = 1'b1;
          first_nxt = scan_r;
          ftgt_nxt  = q_tgt;
        end
      end
      OP_TAKE: begin
        used_nxt[first_r] = 1'b1;
        cur_nxt           = ftgt_r;
        if (depth_r < cnt_t'(MAX_EDGES)) begin
          stack_we  = 1'b1;
          depth_nxt = depth_r + cnt_t'(1);
        end
      end
      OP_PUSH: begin
        if (depth_r < cnt_t'(MAX_EDGES)) begin
          stack_we  = 1'b1;
          depth_nxt = depth_r + cnt_t'(1);
        end
      end
      OP_POP: begin
        depth_nxt   = depth_r - cnt_t'(1);
        stack_raddr = depth_nxt[IW-1:0];
      end
      OP_LOAD: begin
        cur_nxt = stack_q;
      end
      OP_EMIT0: begin
        stack_raddr = '0;
        oi_nxt      = '0;
      end
      OP_EMIT: begin
        oi_nxt        = oi_inc;
        out_valid_nxt = 1'b1;
        out_node_nxt  = node_ext[7:0];
        out_found_nxt = 1'b1;
        out_last_nxt  = (oi_inc == depth_r);
      end
      OP_FAIL: begin
        out_valid_nxt = 1'b1;
        out_node_nxt  = '0;
        out_found_nxt = 1'b0;
        out_last_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_cnt_r[IW-1:0]] <= {src_id, dst_id};
    end
    edge_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[depth_r[IW-1:0]] <= cur_r;
    end
    stack_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      edge_cnt_r  <= '0;
      depth_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      depth_r     <= depth_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    goal_r      <= goal_nxt;
    scan_r      <= scan_nxt;
    first_r     <= first_nxt;
    ftgt_r      <= ftgt_nxt;
    direct_r    <= direct_nxt;
    found_r     <= found_nxt;
    oi_r        <= oi_nxt;
    out_node_r  <= out_node_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_path_node = out_node_r;
  assign out_found     = out_found_r;
  assign out_last      = out_last_r;

endmodule

@@ tb/tb_dfs_backtrack_path_search.sv @@
// Testbench for dfs_backtrack_path_search: directed and random add/query words against
// a scoreboard that searches its own copy of the edge table. Depends on the RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAX_EDGES  = 64;
  localparam int  N_RANDOM   = 150;
  localparam int  IDLE_LIMIT = 40000;
  localparam bit  KIND_ADD   = 1'b0;
  localparam bit  KIND_QUERY = 1'b1;

  typedef struct {
    bit [7:0] path_node;
    bit       found;
    bit       last;
  } path_step_t;

  class path_scoreboard;
    bit [7:0]   edge_from [MAX_EDGES];
    bit [7:0]   edge_to   [MAX_EDGES];
    bit         edge_taken[MAX_EDGES];
    int         n_edges;
    bit [7:0]   trail[MAX_EDGES];
    int         trail_len;
    path_step_t expected_steps[$];
    int         errors, n_queries, n_adds, n_dropped, n_found, n_checked;

    function bit direct_edge(bit [7:0] from, bit [7:0] goal);
      for (int i = 0; i < n_edges; i++)
        if (edge_from[i] == from && edge_to[i] == goal) return 1'b1;
      return 1'b0;
    endfunction

    function int first_untaken(bit [7:0] from);
      for (int i = 0; i < n_edges; i++)
        if (edge_from[i] == from && !edge_taken[i]) return i;
      return n_edges;
    endfunction

    function void push_node(bit [7:0] node);
      if (trail_len < MAX_EDGES) begin
        trail[trail_len] = node;
        trail_len++;
      end
    endfunction

    function void note_word(bit kind, bit [7:0] src, bit [7:0] dst);
      bit [7:0]   cur;
      bit         hit;
      bit         searching;
      int         e;
      path_step_t s;
      if (kind == KIND_ADD) begin
        n_adds++;
        if (n_edges < MAX_EDGES) begin
          edge_from[n_edges]  = src;
          edge_to[n_edges]    = dst;
          edge_taken[n_edges] = 1'b0;
          n_edges++;
        end else begin
          n_dropped++;
        end
        return;
      end
      n_queries++;
      foreach (edge_taken[i]) edge_taken[i] = 1'b0;
      trail_len = 0;
      cur = src;
      hit = 1'b0;
      searching = 1'b1;
      while (searching) begin
        if (direct_edge(cur, dst)) begin
          push_node(cur);
          hit = 1'b1;
          searching = 1'b0;
        end else begin
          e = first_untaken(cur);
          if (e < n_edges) begin
            edge_taken[e] = 1'b1;
            push_node(cur);
            cur = edge_to[e];
          end else if (trail_len > 0) begin
            trail_len--;
            cur = trail[trail_len];
          end else begin
            searching = 1'b0;
          end
        end
      end
      if (!hit || trail_len == 0) begin
        s = '{path_node: 8'd0, found: 1'b0, last: 1'b1};
        expected_steps.push_back(s);
      end else begin
        n_found++;
        for (int i = 0; i < trail_len; i++) begin
          s = '{path_node: trail[i], found: 1'b1, last: (i == trail_len - 1)};
          expected_steps.push_back(s);
        end
      end
    endfunction

    function void check_result(bit [7:0] node, bit found, bit last);
      path_step_t want;
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected word node %0d found %0b last %0b", $time, node, found, last);
        errors++;
        return;
      end
      want = expected_steps.pop_front();
      n_checked++;
      if (want.path_node != node) begin
        $display("%0t: path_node expected %0d got %0d", $time, want.path_node, node);
        errors++;
      end
      if (want.found != found) begin
        $display("%0t: found expected %0b got %0b", $time, want.found, found);
        errors++;
      end
      if (want.last != last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       start       = 1'b0;
  logic       in_kind     = 1'b0;
  logic [7:0] in_src_node = 8'd0;
  logic [7:0] in_dst_node = 8'd0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_path_node;
  logic       out_found;
  logic       out_last;

  path_scoreboard sb = new();
  int idle_cycles = 0;

  dfs_backtrack_path_search DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_src_node  (in_src_node),
    .in_dst_node  (in_dst_node),
    .out_valid    (out_valid),
    .out_path_node(out_path_node),
    .out_found    (out_found),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_path_node, out_found, out_last);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, sb.expected_steps.size());
      $display("FAIL dfs_backtrack_path_search");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(bit kind, bit [7:0] src, bit [7:0] dst, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_src_node <= src;
    in_dst_node <= dst;
    do @(posedge clk); while (busy);
    sb.note_word(kind, src, dst);
  endtask

  // mostly a small node pool so the graph gets dense; sometimes the full id range
  function automatic bit [7:0] pick_node();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 8'($urandom_range(0, 255));
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 7));
  endfunction

  initial begin
    int counted;
    int gap;
    bit kind;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(KIND_QUERY, 8'd0,   8'd0,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd0,   8'd255, $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd255, 8'd0,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd0,   8'd255, $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd0,   8'd0,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd170, 8'd85,  $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd85,  8'd170, $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd170, 8'd170, $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd1,   8'd7,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd1,   8'd2,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd2,   8'd3,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd3,   8'd4,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd1,   8'd4,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd4,   8'd1,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd5,   8'd5,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd5,   8'd5,   $urandom_range(0, 13));
    send_word(KIND_ADD,   8'd6,   8'd1,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd6,   8'd9,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd6,   8'd3,   $urandom_range(0, 13));
    send_word(KIND_QUERY, 8'd255, 8'd255, $urandom_range(0, 13));

    counted = 0;
    while (counted < N_RANDOM) begin
      gap = ((counted / 25) % 3 == 2) ? 0 : $urandom_range(0, 13);
      if (sb.n_edges < MAX_EDGES) begin
        kind = ($urandom_range(0, 1) == 0) ? KIND_ADD : KIND_QUERY;
        counted++;
      end else begin
        // table full: adds are dropped and do not count
        kind = ($urandom_range(0, 6) == 0) ? KIND_ADD : KIND_QUERY;
        if (kind == KIND_QUERY) counted++;
      end
      send_word(kind, pick_node(), pick_node(), gap);
    end
    start <= 1'b0;

    while (sb.expected_steps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d queries (%0d with a path), %0d adds (%0d dropped on a full table),",
             sb.n_queries, sb.n_found, sb.n_adds, sb.n_dropped);
    $display("%0d result words checked, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS dfs_backtrack_path_search");
    end else begin
      $display("FAIL dfs_backtrack_path_search");
    end
    $finish;
  end

endmodule
